// ===== src/arpr_pkg.sv =====
// Shared types, constants and reply byte helpers for the ARP responder
// and gateway learner. No dependencies.
package arpr_pkg;

    typedef enum logic [1:0] {
        ACT_IGNORE = 2'd0,
        ACT_ANSWER = 2'd1,
        ACT_LEARN  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_LOCAL_IP   = 2'd0,
        CFG_LOCAL_MAC  = 2'd1,
        CFG_GATEWAY_IP = 2'd2
    } t_cfg_index;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [15:0] TYPE_ADDR_RES = 16'h0806;
    localparam logic [15:0] OPER_QUERY    = 16'd1;
    localparam logic [15:0] OPER_RESPONSE = 16'd2;

    // Frame layout (byte offsets from the destination MAC)
    localparam logic [5:0] OFS_TYPE_HI   = 6'd12;
    localparam logic [5:0] OFS_TYPE_LO   = 6'd13;
    localparam logic [5:0] OFS_OPER_HI   = 6'd20;
    localparam logic [5:0] OFS_OPER_LO   = 6'd21;
    localparam logic [5:0] OFS_SHA_FIRST = 6'd22;
    localparam logic [5:0] OFS_SHA_LAST  = 6'd27;
    localparam logic [5:0] OFS_SPA_FIRST = 6'd28;
    localparam logic [5:0] OFS_SPA_LAST  = 6'd31;
    localparam logic [5:0] OFS_THA_FIRST = 6'd32;
    localparam logic [5:0] OFS_THA_LAST  = 6'd37;
    localparam logic [5:0] OFS_TPA_FIRST = 6'd38;
    localparam logic [5:0] OFS_TPA_LAST  = 6'd41;
    localparam logic [5:0] REPLY_LEN     = 6'd42;
    localparam logic [5:0] INDEX_MAX     = 6'd63;

    localparam logic [31:0] LOCAL_IP_RST   = 32'h0A00_020F;
    localparam logic [47:0] LOCAL_MAC_RST  = 48'h0;
    localparam logic [31:0] GATEWAY_IP_RST = 32'h0A00_0202;
    localparam logic [47:0] GW_MAC_RST     = 48'h5254_0012_3456;

    typedef struct packed {
        logic        done;
        t_action     action;
        logic [47:0] gw_mac;
        logic        gw_known;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
    } t_frame_end;

    function automatic logic [7:0] mac_byte(input logic [47:0] v, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = v[47:40];
            3'd1:    b = v[39:32];
            3'd2:    b = v[31:24];
            3'd3:    b = v[23:16];
            3'd4:    b = v[15:8];
            3'd5:    b = v[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

    // Byte p of the ARP reply frame
    function automatic logic [7:0] reply_byte(
        input logic [5:0]  p,
        input logic [47:0] peer_mac,
        input logic [31:0] peer_ip,
        input logic [47:0] local_mac,
        input logic [31:0] local_ip
    );
        logic [7:0] b;
        logic [5:0] k;
        b = 8'h00;
        k = 6'd0;
        if (p < 6'd6) begin
            b = mac_byte(peer_mac, p[2:0]);
        end else if (p < 6'd12) begin
            k = p - 6'd6;
            b = mac_byte(local_mac, k[2:0]);
        end else if (p < OFS_SHA_FIRST) begin
            case (p)
                6'd12:   b = 8'h08;
                6'd13:   b = 8'h06;
                6'd14:   b = 8'h00;
                6'd15:   b = 8'h01;
                6'd16:   b = 8'h08;
                6'd17:   b = 8'h00;
                6'd18:   b = 8'h06;
                6'd19:   b = 8'h04;
                6'd20:   b = 8'h00;
                default: b = 8'h02;
            endcase
        end else if (p <= OFS_SHA_LAST) begin
            k = p - OFS_SHA_FIRST;
            b = mac_byte(local_mac, k[2:0]);
        end else if (p <= OFS_SPA_LAST) begin
            k = p - OFS_SPA_FIRST;
            b = ip_byte(local_ip, k[1:0]);
        end else if (p <= OFS_THA_LAST) begin
            k = p - OFS_THA_FIRST;
            b = mac_byte(peer_mac, k[2:0]);
        end else begin
            k = p - OFS_TPA_FIRST;
            b = ip_byte(peer_ip, k[1:0]);
        end
        return b;
    endfunction

endpackage

// ===== src/arpr_rx_parse.sv =====
// Receive side: byte counter, ARP header capture and frame-end decision.
// Holds the gateway MAC cache. Depends on arpr_pkg.
module arpr_rx_parse import arpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    input  logic [31:0] i_local_ip,
    input  logic [31:0] i_gateway_ip,
    output t_frame_end  o_fe
);

    logic [5:0]  r_byte_index, n_byte_index;
    logic [15:0] r_frame_type, n_frame_type;
    logic [15:0] r_arp_opcode, n_arp_opcode;
    logic [47:0] r_peer_mac,   n_peer_mac;
    logic [31:0] r_peer_ip,    n_peer_ip;
    logic [31:0] r_asked_ip,   n_asked_ip;
    logic [47:0] r_gw_mac,     n_gw_mac;
    logic        r_gw_valid,   n_gw_valid;
    t_action     w_action;
    logic [5:0]  w_idx;

    always_comb begin
        w_idx        = r_byte_index;
        n_byte_index = r_byte_index;
        n_frame_type = r_frame_type;
        n_arp_opcode = r_arp_opcode;
        n_peer_mac   = r_peer_mac;
        n_peer_ip    = r_peer_ip;
        n_asked_ip   = r_asked_ip;
        n_gw_mac     = r_gw_mac;
        n_gw_valid   = r_gw_valid;
        w_action     = ACT_IGNORE;

        if (i_accept) begin
            if (w_idx == OFS_TYPE_HI || w_idx == OFS_TYPE_LO) begin
                n_frame_type = {r_frame_type[7:0], i_rx_byte};
            end else if (w_idx == OFS_OPER_HI || w_idx == OFS_OPER_LO) begin
                n_arp_opcode = {r_arp_opcode[7:0], i_rx_byte};
            end else if (w_idx >= OFS_SHA_FIRST && w_idx <= OFS_SHA_LAST) begin
                n_peer_mac = {r_peer_mac[39:0], i_rx_byte};
            end else if (w_idx >= OFS_SPA_FIRST && w_idx <= OFS_SPA_LAST) begin
                n_peer_ip = {r_peer_ip[23:0], i_rx_byte};
            end else if (w_idx >= OFS_TPA_FIRST && w_idx <= OFS_TPA_LAST) begin
                n_asked_ip = {r_asked_ip[23:0], i_rx_byte};
            end

            // saturate on long frames
            if (w_idx != INDEX_MAX) begin
                n_byte_index = w_idx + 6'd1;
            end

            if (i_rx_last) begin
                n_byte_index = 6'd0;
                // short frames fall through as ignored
                if (w_idx >= OFS_TPA_LAST && n_frame_type == TYPE_ADDR_RES) begin
                    if (n_arp_opcode == OPER_QUERY && n_asked_ip == i_local_ip) begin
                        w_action = ACT_ANSWER;
                    end else if (n_arp_opcode == OPER_RESPONSE &&
                                 n_peer_ip == i_gateway_ip) begin
                        w_action   = ACT_LEARN;
                        n_gw_mac   = n_peer_mac;
                        n_gw_valid = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 6'd0;
            r_frame_type <= 16'd0;
            r_arp_opcode <= 16'd0;
            r_peer_mac   <= 48'd0;
            r_peer_ip    <= 32'd0;
            r_asked_ip   <= 32'd0;
            r_gw_mac     <= GW_MAC_RST;
            r_gw_valid   <= 1'b0;
        end else begin
            r_byte_index <= n_byte_index;
            r_frame_type <= n_frame_type;
            r_arp_opcode <= n_arp_opcode;
            r_peer_mac   <= n_peer_mac;
            r_peer_ip    <= n_peer_ip;
            r_asked_ip   <= n_asked_ip;
            r_gw_mac     <= n_gw_mac;
            r_gw_valid   <= n_gw_valid;
        end
    end

    always_comb begin
        o_fe.done     = i_accept && i_rx_last;
        o_fe.action   = w_action;
        o_fe.gw_mac   = n_gw_mac;
        o_fe.gw_known = n_gw_valid;
        o_fe.peer_mac = n_peer_mac;
        o_fe.peer_ip  = n_peer_ip;
    end

endmodule

// ===== src/arp_responder_and_gateway_learner_top.sv =====
// Top level: configuration registers, ARP reply byte sequencer and result register.
// Depends on arpr_pkg and arpr_rx_parse.
// Output: the status item of a frame that is not answered appears in the cycle after its
// last byte is taken; for an answered request the reply sequencer then sends the 42 reply
// bytes, one per cycle while the output is not stalled, and its status item follows them.
// Throughput: one received byte per cycle. A frame's last byte is held off while a
// reply is still being sent or the result register is blocked; other bytes always flow.
// Reset (synchronous, active low): capture state cleared, gateway MAC 52:54:00:12:34:56,
// registers to their defaults, result register empty.
module arp_responder_and_gateway_learner_top import arpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    output logic        o_tx_valid,
    input  logic        i_tx_stall,
    output logic        o_item_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_run_last,
    output logic [1:0]  o_frame_action,
    output logic [47:0] o_gateway_mac_out,
    output logic        o_gateway_known,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic [31:0] r_local_ip;
    logic [47:0] r_local_mac;
    logic [31:0] r_gateway_ip;

    logic        r_gen_active, n_gen_active;
    logic [5:0]  r_gen_pos,    n_gen_pos;
    logic [47:0] r_rep_mac;
    logic [31:0] r_rep_ip;

    logic        r_out_valid,  n_out_valid;
    logic        r_out_kind,   n_out_kind;
    logic [7:0]  r_out_byte,   n_out_byte;
    logic        r_out_last,   n_out_last;
    t_action     r_out_action, n_out_action;
    logic [47:0] r_out_gw_mac;
    logic        r_out_gw_known;

    logic        w_out_adv;
    logic        w_rx_accept;
    logic        w_start;
    t_frame_end  w_fe;

    assign w_out_adv   = !r_out_valid || !i_tx_stall;
    assign o_rx_stall  = i_rx_last && (r_gen_active || !w_out_adv);
    assign w_rx_accept = i_rx_valid && !o_rx_stall;
    assign o_cfg_ready = 1'b1;

    arpr_rx_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_rx_accept),
        .i_rx_byte    (i_rx_byte),
        .i_rx_last    (i_rx_last),
        .i_local_ip   (r_local_ip),
        .i_gateway_ip (r_gateway_ip),
        .o_fe         (w_fe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip   <= LOCAL_IP_RST;
            r_local_mac  <= LOCAL_MAC_RST;
            r_gateway_ip <= GATEWAY_IP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOCAL_IP:   r_local_ip   <= i_cfg_data[31:0];
                CFG_LOCAL_MAC:  r_local_mac  <= i_cfg_data;
                CFG_GATEWAY_IP: r_gateway_ip <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_gen_active = r_gen_active;
        n_gen_pos    = r_gen_pos;
        n_out_valid  = r_out_valid;
        n_out_kind   = KIND_STATUS;
        n_out_byte   = 8'h00;
        n_out_last   = 1'b1;
        n_out_action = ACT_IGNORE;
        w_start      = 1'b0;

        if (w_out_adv) begin
            if (r_gen_active) begin
                n_out_valid = 1'b1;
                if (r_gen_pos == REPLY_LEN) begin
                    // reply done: close with the status item
                    n_out_action = ACT_ANSWER;
                    n_gen_active = 1'b0;
                end else begin
                    n_out_kind = KIND_BYTE;
                    n_out_byte = reply_byte(r_gen_pos, r_rep_mac, r_rep_ip,
                                            r_local_mac, r_local_ip);
                    n_out_last = 1'b0;
                    n_gen_pos  = r_gen_pos + 6'd1;
                end
            end else if (w_fe.done && w_fe.action != ACT_ANSWER) begin
                n_out_valid  = 1'b1;
                n_out_action = w_fe.action;
            end else begin
                n_out_valid = 1'b0;
                if (w_fe.done) begin
                    w_start      = 1'b1;
                    n_gen_active = 1'b1;
                    n_gen_pos    = 6'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_active <= 1'b0;
            r_gen_pos    <= 6'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_gen_active <= n_gen_active;
            r_gen_pos    <= n_gen_pos;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rep_mac <= w_fe.peer_mac;
            r_rep_ip  <= w_fe.peer_ip;
        end
        if (w_out_adv) begin
            r_out_kind     <= n_out_kind;
            r_out_byte     <= n_out_byte;
            r_out_last     <= n_out_last;
            r_out_action   <= n_out_action;
            r_out_gw_mac   <= w_fe.gw_mac;
            r_out_gw_known <= w_fe.gw_known;
        end
    end

    assign o_tx_valid        = r_out_valid;
    assign o_item_kind       = r_out_kind;
    assign o_tx_byte         = r_out_byte;
    assign o_run_last        = r_out_last;
    assign o_frame_action    = r_out_action;
    assign o_gateway_mac_out = r_out_gw_mac;
    assign o_gateway_known   = r_out_gw_known;

endmodule
